// ===== hw/rtl/mesp_pkg.sv =====
// Shared widths and types for the modular power and strong prime test block.
`timescale 1ns / 1ps
`default_nettype none
package mesp_pkg;
  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mesp_mulmod.sv =====
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mesp_mulmod import mesp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t a,
  input  word_t b,
  input  word_t n,
  output logic  done,
  output word_t product
);

  logic  running;
  cnt_t  cnt;
  word_t acc;
  word_t mcand;
  word_t mplier;
  word_t modn;

  logic [WIDTH:0] dbl;
  logic [WIDTH:0] nx;
  word_t          half;
  word_t          addend;
  logic [WIDTH:0] sum;
  word_t          acc_next;

  always_comb begin
    nx     = {1'b0, modn};
    dbl    = {acc, 1'b0};
    half   = (dbl >= nx) ? WIDTH'(dbl - nx) : dbl[WIDTH-1:0];
    addend = mplier[WIDTH-1] ? mcand : '0;
    sum    = {1'b0, half} + {1'b0, addend};
    acc_next = (sum >= nx) ? WIDTH'(sum - nx) : sum[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start && !running) begin
        running <= 1'b1;
        cnt     <= CNT_W'(WIDTH - 1);
        acc     <= '0;
        mcand   <= a;
        mplier  <= b;
        modn    <= n;
      end else if (running) begin
        acc    <= acc_next;
        mplier <= {mplier[WIDTH-2:0], 1'b0};
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule
`default_nettype wire

// ===== hw/rtl/modexp_and_strong_prime_test_top.sv =====
// Top level: modular exponentiation and single-base strong probable-prime test.
`timescale 1ns / 1ps
`default_nettype none
// A word is taken when start is high while busy is low. Mode 0 returns
// base^exponent mod modulus, and mode 1 runs one strong probable-prime round
// on the modulus with the base as witness. Every product goes through one
// shared bit-serial modular multiplier. In mode 1 the trailing zeros of
// modulus-1 are shifted out first; then the base is reduced, and each
// exponent bit up to the highest set bit takes a squaring, preceded by a
// multiply into the result when the bit is set; in mode 1 each squaring
// round takes one more product. An invalid modulus is answered in the
// cycle right after acceptance. The result is shown for exactly one cycle
// with done high, and the receiver cannot stall it.
module modexp_and_strong_prime_test_top import mesp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  logic  mode,
  input  word_t base,
  input  word_t exponent,
  input  word_t modulus,
  output logic  done,
  output word_t power_value,
  output logic  probably_prime,
  output logic  invalid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FACTOR,
    S_REDUCE,
    S_RED_WAIT,
    S_LOOP,
    S_MULP_WAIT,
    S_SQA_WAIT,
    S_POW_END,
    S_TEST,
    S_TSQ_WAIT
  } state_t;

  state_t state;
  logic   mode_r;
  word_t  nreg;
  word_t  areg;
  word_t  preg;
  word_t  ereg;
  cnt_t   sreg;

  logic   mul_start;
  word_t  mul_a;
  word_t  mul_b;
  logic   mul_done;
  word_t  mul_prod;
  word_t  nm1;

  assign nm1  = nreg - word_t'(1);
  assign busy = (state != S_IDLE);

  mesp_mulmod u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .n       (nreg),
    .done    (mul_done),
    .product (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      mul_start      <= 1'b0;
      power_value    <= '0;
      probably_prime <= 1'b0;
      invalid        <= 1'b0;
    end else begin
      done      <= 1'b0;
      mul_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mode_r <= mode;
            nreg   <= modulus;
            areg   <= base;
            sreg   <= '0;
            if (!mode) begin
              ereg <= exponent;
              if (modulus == '0) begin
                done           <= 1'b1;
                power_value    <= '0;
                probably_prime <= 1'b0;
                invalid        <= 1'b1;
              end else begin
                state <= S_REDUCE;
              end
            end else begin
              ereg <= modulus - word_t'(1);
              if (modulus < word_t'(3)) begin
                done           <= 1'b1;
                power_value    <= '0;
                probably_prime <= 1'b0;
                invalid        <= 1'b1;
              end else begin
                state <= S_FACTOR;
              end
            end
          end
        end
        S_FACTOR: begin
          if (!ereg[0]) begin
            ereg <= ereg >> 1;
            sreg <= sreg + 1'b1;
          end else begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          preg <= word_t'(1);
          if (nreg == word_t'(1)) begin
            areg  <= '0;
            state <= S_LOOP;
          end else begin
            mul_start <= 1'b1;
            mul_a     <= word_t'(1);
            mul_b     <= areg;
            state     <= S_RED_WAIT;
          end
        end
        S_RED_WAIT: begin
          if (mul_done) begin
            areg  <= mul_prod;
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (ereg == '0) begin
            state <= S_POW_END;
          end else if (ereg[0]) begin
            mul_start <= 1'b1;
            mul_a     <= areg;
            mul_b     <= preg;
            state     <= S_MULP_WAIT;
          end else begin
            mul_start <= 1'b1;
            mul_a     <= areg;
            mul_b     <= areg;
            state     <= S_SQA_WAIT;
          end
        end
        S_MULP_WAIT: begin
          if (mul_done) begin
            preg      <= mul_prod;
            mul_start <= 1'b1;
            mul_a     <= areg;
            mul_b     <= areg;
            state     <= S_SQA_WAIT;
          end
        end
        S_SQA_WAIT: begin
          if (mul_done) begin
            areg  <= mul_prod;
            ereg  <= ereg >> 1;
            state <= S_LOOP;
          end
        end
        S_POW_END: begin
          if (!mode_r) begin
            done           <= 1'b1;
            power_value    <= preg;
            probably_prime <= 1'b0;
            invalid        <= 1'b0;
            state          <= S_IDLE;
          end else if (preg == word_t'(1)) begin
            done           <= 1'b1;
            power_value    <= '0;
            probably_prime <= 1'b1;
            invalid        <= 1'b0;
            state          <= S_IDLE;
          end else begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (sreg == '0 || preg == word_t'(1)) begin
            done           <= 1'b1;
            power_value    <= '0;
            probably_prime <= 1'b0;
            invalid        <= 1'b0;
            state          <= S_IDLE;
          end else if (preg == nm1) begin
            done           <= 1'b1;
            power_value    <= '0;
            probably_prime <= 1'b1;
            invalid        <= 1'b0;
            state          <= S_IDLE;
          end else begin
            mul_start <= 1'b1;
            mul_a     <= preg;
            mul_b     <= preg;
            sreg      <= sreg - 1'b1;
            state     <= S_TSQ_WAIT;
          end
        end
        S_TSQ_WAIT: begin
          if (mul_done) begin
            preg  <= mul_prod;
            state <= S_TEST;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
